### hdl/serial_fifo_xon_xoff_flow_control_assert.svh
// ----------------------------------------------------------------------------
// serial_fifo_xon_xoff_flow_control_assert.svh
// Assertion macros shared by the serial fifo block.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FIFO_XON_XOFF_FLOW_CONTROL_ASSERT_SVH
`define SERIAL_FIFO_XON_XOFF_FLOW_CONTROL_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SFX_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sfx assertion failed");

// next-cycle implication, checked out of reset
`define SFX_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sfx assertion failed");

`endif

### hdl/sfx_pkg.sv
// ----------------------------------------------------------------------------
// sfx_pkg
// Types, codes and constants of the serial fifo with xon/xoff flow control.
// ----------------------------------------------------------------------------
`default_nettype none

package sfx_pkg;

    // default ring sizes
    localparam int RX_DEPTH_DEF = 4096;
    localparam int TX_DEPTH_DEF = 128;

    // field widths
    localparam int OP_W       = 3;
    localparam int BYTE_W     = 8;
    localparam int LEVEL_W    = 12;
    localparam int TXF_W      = 7;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // flow control characters
    localparam logic [BYTE_W-1:0] CH_XON  = 8'd17;
    localparam logic [BYTE_W-1:0] CH_XOFF = 8'd19;

    // configuration reset values
    localparam logic [LEVEL_W-1:0] XOFF_LEVEL_RST = 12'd512;
    localparam logic [LEVEL_W-1:0] XON_LEVEL_RST  = 12'd409;

    typedef enum logic [OP_W-1:0] {
        OP_LINE_RX  = 3'd0,
        OP_POP      = 3'd1,
        OP_FLUSH    = 3'd2,
        OP_QUEUE    = 3'd3,
        OP_TX_READY = 3'd4,
        OP_LINE_ERR = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        FLOW_XON_SENT    = 2'd0,
        FLOW_XOFF_SENT   = 2'd1,
        FLOW_XON_PENDING = 2'd2
    } flow_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLOW_EN    = 2'd0,
        CFG_XOFF_LEVEL = 2'd1,
        CFG_XON_LEVEL  = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] line_byte;
        logic [BYTE_W-1:0] send_byte;
        logic              overrun_flag;
        logic              framing_flag;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  head_byte;
        logic               head_valid;
        logic [BYTE_W-1:0]  line_out_byte;
        logic               line_out_valid;
        logic [LEVEL_W-1:0] rx_fill;
        logic [TXF_W-1:0]   tx_fill;
        logic               queue_accepted;
        logic [CNT_W-1:0]   dropped_count;
        logic [CNT_W-1:0]   overrun_count;
        logic [CNT_W-1:0]   framing_count;
        logic [LEVEL_W-1:0] peak_fill;
        logic [1:0]         flow_mode;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic commit;
    } cmd_t;

    // saturating 8-bit increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

### hdl/sfx_ram.sv
// ----------------------------------------------------------------------------
// sfx_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/sfx_ctrl.sv
// ----------------------------------------------------------------------------
// sfx_ctrl
// Controller: takes one item, runs its execute cycle, strobes the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_fifo_xon_xoff_flow_control_assert.svh"

module sfx_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output sfx_pkg::cmd_t cmd
);

    import sfx_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_reg;
    logic        done_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        busy       = 1'b0;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_EXEC:
            begin
                cmd.commit = 1'b1;
                busy       = 1'b1;
                done_next  = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;

    `SFX_ASSERT_NEXT(a_accept_runs, clk, rst_n, start && !busy, busy)
    `SFX_ASSERT_NEXT(a_exec_reports, clk, rst_n, busy, done && !busy)
    `SFX_ASSERT_IMPL(a_busy_commits_only, clk, rst_n, busy, cmd.commit && !cmd.load)

endmodule

`default_nettype wire

### hdl/sfx_dpath.sv
// ----------------------------------------------------------------------------
// sfx_dpath
// Datapath: receive and transmit rings, flow state, counters and config.
// ----------------------------------------------------------------------------
`default_nettype none

module sfx_dpath #(
    parameter int RX_DEPTH = sfx_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = sfx_pkg::TX_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sfx_pkg::cmd_t                        cmd,
    input  sfx_pkg::item_t                       item,
    input  logic                                 cfg_write,
    input  logic [sfx_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sfx_pkg::CFG_DATA_W-1:0]       cfg_data,
    output sfx_pkg::result_t                     result
);

    import sfx_pkg::*;

    localparam int RX_AW  = $clog2(RX_DEPTH);
    localparam int TX_AW  = $clog2(TX_DEPTH);
    localparam int CMP_W  = (RX_AW > LEVEL_W) ? RX_AW : LEVEL_W;
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
    localparam logic [RX_AW:0]   RX_SPAN = (RX_AW + 1)'(RX_DEPTH);
    localparam logic [TX_AW:0]   TX_SPAN = (TX_AW + 1)'(TX_DEPTH);

    // pointers, flow state, counters
    logic [RX_AW-1:0]   rx_wr_reg, rx_wr_next, rx_rd_reg, rx_rd_next;
    logic [TX_AW-1:0]   tx_wr_reg, tx_wr_next, tx_rd_reg, tx_rd_next;
    flow_t              flow_reg, flow_next;
    logic [CNT_W-1:0]   drop_reg, drop_next, ovr_reg, ovr_next, frm_reg, frm_next;
    logic [RX_AW-1:0]   peak_reg, peak_next;

    // configuration
    logic               flow_en_reg, flow_en_next;
    logic [LEVEL_W-1:0] xoff_reg, xoff_next, xon_reg, xon_next;

    // payload
    item_t              item_reg;
    result_t            result_reg, result_next;

    // ring helpers
    logic [RX_AW-1:0]   rx_wr_inc, rx_rd_inc;
    logic [TX_AW-1:0]   tx_wr_inc, tx_rd_inc;
    logic               head_valid, rx_full, tx_full, tx_empty;
    logic [RX_AW:0]     rx_diff, rx_wrap;
    logic [TX_AW:0]     tx_diff, tx_wrap;
    logic [RX_AW-1:0]   rx_fill_new;
    logic [TX_AW-1:0]   tx_fill_new;
    logic [BYTE_W-1:0]  rx_rdata, tx_rdata;
    logic               rx_we, tx_we;
    logic [BYTE_W-1:0]  lo_byte;
    logic               lo_valid, accepted;

    // ring memories
    sfx_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(RX_DEPTH)
    ) u_rx_ram (
        .clk  (clk),
        .we   (rx_we),
        .waddr(rx_wr_reg),
        .wdata(item_reg.line_byte),
        .raddr(rx_rd_reg),
        .rdata(rx_rdata)
    );

    sfx_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(TX_DEPTH)
    ) u_tx_ram (
        .clk  (clk),
        .we   (tx_we),
        .waddr(tx_wr_reg),
        .wdata(item_reg.send_byte),
        .raddr(tx_rd_reg),
        .rdata(tx_rdata)
    );

    // pointer increments with wrap
    assign rx_wr_inc = (rx_wr_reg == RX_LAST) ? '0 : rx_wr_reg + 1'b1;
    assign rx_rd_inc = (rx_rd_reg == RX_LAST) ? '0 : rx_rd_reg + 1'b1;
    assign tx_wr_inc = (tx_wr_reg == TX_LAST) ? '0 : tx_wr_reg + 1'b1;
    assign tx_rd_inc = (tx_rd_reg == TX_LAST) ? '0 : tx_rd_reg + 1'b1;

    assign head_valid = (rx_wr_reg != rx_rd_reg);
    assign rx_full    = (rx_wr_inc == rx_rd_reg);
    assign tx_full    = (tx_wr_inc == tx_rd_reg);
    assign tx_empty   = (tx_wr_reg == tx_rd_reg);

    // pointers, ram writes and counters
    always_comb
    begin
        rx_wr_next = rx_wr_reg;
        rx_rd_next = rx_rd_reg;
        tx_wr_next = tx_wr_reg;
        tx_rd_next = tx_rd_reg;
        drop_next  = drop_reg;
        ovr_next   = ovr_reg;
        frm_next   = frm_reg;
        rx_we      = 1'b0;
        tx_we      = 1'b0;
        accepted   = 1'b0;
        if (cmd.commit)
        begin
            case (item_reg.op)
                OP_LINE_RX:
                begin
                    if (!rx_full)
                    begin
                        rx_we      = 1'b1;
                        rx_wr_next = rx_wr_inc;
                    end
                    else
                    begin
                        drop_next = sat_inc(drop_reg);
                    end
                end
                OP_POP:
                begin
                    if (head_valid)
                    begin
                        rx_rd_next = rx_rd_inc;
                    end
                end
                OP_FLUSH:
                begin
                    rx_rd_next = rx_wr_reg;
                end
                OP_QUEUE:
                begin
                    if (!tx_full)
                    begin
                        tx_we      = 1'b1;
                        tx_wr_next = tx_wr_inc;
                        accepted   = 1'b1;
                    end
                end
                OP_TX_READY:
                begin
                    if (flow_reg != FLOW_XON_PENDING && !tx_empty)
                    begin
                        tx_rd_next = tx_rd_inc;
                    end
                end
                OP_LINE_ERR:
                begin
                    if (item_reg.overrun_flag)
                    begin
                        drop_next = sat_inc(drop_reg);
                        ovr_next  = sat_inc(ovr_reg);
                    end
                    if (item_reg.framing_flag)
                    begin
                        frm_next = sat_inc(frm_reg);
                    end
                end
                default:
                begin
                    accepted = 1'b0;
                end
            endcase
        end
    end

    // fills after the item
    assign rx_diff     = {1'b0, rx_wr_next} - {1'b0, rx_rd_next};
    assign rx_wrap     = rx_diff + RX_SPAN;
    assign rx_fill_new = (rx_wr_next >= rx_rd_next) ? rx_diff[RX_AW-1:0] : rx_wrap[RX_AW-1:0];
    assign tx_diff     = {1'b0, tx_wr_next} - {1'b0, tx_rd_next};
    assign tx_wrap     = tx_diff + TX_SPAN;
    assign tx_fill_new = (tx_wr_next >= tx_rd_next) ? tx_diff[TX_AW-1:0] : tx_wrap[TX_AW-1:0];

    // flow state, peak mark and line output
    always_comb
    begin
        flow_next = flow_reg;
        peak_next = peak_reg;
        lo_byte   = '0;
        lo_valid  = 1'b0;
        if (cmd.commit)
        begin
            case (item_reg.op)
                OP_LINE_RX:
                begin
                    if (rx_fill_new > peak_reg)
                    begin
                        peak_next = rx_fill_new;
                    end
                    if (flow_en_reg && flow_reg != FLOW_XOFF_SENT
                        && CMP_W'(rx_fill_new) >= CMP_W'(xoff_reg))
                    begin
                        flow_next = FLOW_XOFF_SENT;
                        lo_byte   = CH_XOFF;
                        lo_valid  = 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (head_valid && flow_en_reg && flow_reg == FLOW_XOFF_SENT
                        && CMP_W'(rx_fill_new) < CMP_W'(xon_reg))
                    begin
                        flow_next = FLOW_XON_PENDING;
                    end
                end
                OP_FLUSH:
                begin
                    if (flow_en_reg && flow_reg == FLOW_XOFF_SENT)
                    begin
                        flow_next = FLOW_XON_PENDING;
                    end
                end
                OP_TX_READY:
                begin
                    if (flow_reg == FLOW_XON_PENDING)
                    begin
                        flow_next = FLOW_XON_SENT;
                        lo_byte   = CH_XON;
                        lo_valid  = 1'b1;
                    end
                    else if (!tx_empty)
                    begin
                        lo_byte  = tx_rdata;
                        lo_valid = 1'b1;
                    end
                end
                default:
                begin
                    lo_valid = 1'b0;
                end
            endcase
        end
    end

    // result assembly
    always_comb
    begin
        result_next.head_byte      = head_valid ? rx_rdata : '0;
        result_next.head_valid     = head_valid;
        result_next.line_out_byte  = lo_byte;
        result_next.line_out_valid = lo_valid;
        result_next.rx_fill        = LEVEL_W'(rx_fill_new);
        result_next.tx_fill        = TXF_W'(tx_fill_new);
        result_next.queue_accepted = accepted;
        result_next.dropped_count  = drop_next;
        result_next.overrun_count  = ovr_next;
        result_next.framing_count  = frm_next;
        result_next.peak_fill      = LEVEL_W'(peak_next);
        result_next.flow_mode      = flow_next;
    end

    // configuration writes
    always_comb
    begin
        flow_en_next = flow_en_reg;
        xoff_next    = xoff_reg;
        xon_next     = xon_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_FLOW_EN:    flow_en_next = cfg_data[0];
                CFG_XOFF_LEVEL: xoff_next    = LEVEL_W'(cfg_data);
                CFG_XON_LEVEL:  xon_next     = LEVEL_W'(cfg_data);
                default:        flow_en_next = flow_en_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wr_reg   <= '0;
            rx_rd_reg   <= '0;
            tx_wr_reg   <= '0;
            tx_rd_reg   <= '0;
            flow_reg    <= FLOW_XON_SENT;
            drop_reg    <= '0;
            ovr_reg     <= '0;
            frm_reg     <= '0;
            peak_reg    <= '0;
            flow_en_reg <= 1'b1;
            xoff_reg    <= XOFF_LEVEL_RST;
            xon_reg     <= XON_LEVEL_RST;
        end
        else
        begin
            rx_wr_reg   <= rx_wr_next;
            rx_rd_reg   <= rx_rd_next;
            tx_wr_reg   <= tx_wr_next;
            tx_rd_reg   <= tx_rd_next;
            flow_reg    <= flow_next;
            drop_reg    <= drop_next;
            ovr_reg     <= ovr_next;
            frm_reg     <= frm_next;
            peak_reg    <= peak_next;
            flow_en_reg <= flow_en_next;
            xoff_reg    <= xoff_next;
            xon_reg     <= xon_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

### hdl/serial_fifo_xon_xoff_flow_control.sv
// ----------------------------------------------------------------------------
// serial_fifo_xon_xoff_flow_control
// Serial receive/transmit ring buffers with xon/xoff software flow control.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  item      start / busy           item   (sfx_pkg::item_t)
//  result    done strobe            result (sfx_pkg::result_t)
//  config    cfg_write              cfg_index, cfg_data
//
//  an item is taken when start is high and busy low; busy is high for the
//  one execute cycle that follows, and done pulses in the cycle after it
//  a new item can be taken in the done cycle, but not while busy is high;
//  reset clears pointers, counters and the peak mark, and sets flow state
//  and config to their reset values; the rings are not reset;
//  nothing stalls the result side, each beat is valid for one cycle only
// ----------------------------------------------------------------------------
`default_nettype none

module serial_fifo_xon_xoff_flow_control #(
    parameter int RX_DEPTH = sfx_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = sfx_pkg::TX_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sfx_pkg::item_t                 item,
    output logic                           done,
    output sfx_pkg::result_t               result,
    input  logic                           cfg_write,
    input  logic [sfx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfx_pkg::CFG_DATA_W-1:0] cfg_data
);

    import sfx_pkg::*;

    cmd_t cmd;

    // sequencer
    sfx_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .done (done),
        .cmd  (cmd)
    );

    // rings, flow state and counters
    sfx_dpath #(
        .RX_DEPTH(RX_DEPTH),
        .TX_DEPTH(TX_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item     (item),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

`default_nettype wire
